>>> rtl/lta_pkg.sv
// Shared types and constants for the LoRa airtime calculator.
package lta_pkg;

  localparam logic [3:0]  SF_MIN         = 4'd7;
  localparam logic [3:0]  SF_MAX         = 4'd12;
  localparam logic [2:0]  CR_MIN         = 3'd1;
  localparam logic [2:0]  CR_MAX         = 3'd4;
  localparam logic [1:0]  BW_MAX         = 2'd2;
  localparam logic [15:0] PREAMBLE_RESET = 16'd8;
  localparam int unsigned RECIP_SHIFT    = 18;

  // Symbol count and airtime shift handed from the divider pipe to the airtime stages.
  typedef struct packed {
    logic [9:0] symbols;
    logic [3:0] shift;
  } lta_sym_t;

  // ceil(2^RECIP_SHIFT / d); exact quotients for dividends up to 525.
  function automatic logic [15:0] lta_recip(input logic [3:0] d);
    logic [15:0] r;
    case (d)
      4'd5:    r = 16'd52429;
      4'd6:    r = 16'd43691;
      4'd7:    r = 16'd37450;
      4'd8:    r = 16'd32768;
      4'd9:    r = 16'd29128;
      4'd10:   r = 16'd26215;
      4'd11:   r = 16'd23832;
      4'd12:   r = 16'd21846;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/lta_sym.sv
// Three-stage pipe computing the payload symbol count and the airtime shift.
module lta_sym import lta_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [3:0] spreading_factor_i,
  input  logic [7:0] payload_length_i,
  input  logic [2:0] coding_rate_i,
  input  logic [1:0] bandwidth_code_i,
  input  logic       implicit_header_i,
  input  logic       low_rate_optimize_i,
  output logic       valid_o,
  output lta_sym_t   sym_o
);

  // stage 1: clamp, numerator, reduced dividend, reciprocal lookup
  logic [3:0]  sf_c;
  logic [2:0]  cr_c;
  logic [1:0]  bw_c;
  logic [12:0] num;
  logic [3:0]  dv;
  logic [12:0] x;
  logic        pos;

  logic        v1_q;
  logic [9:0]  n1_q;
  logic [15:0] r1_q;
  logic [2:0]  cr1_q;
  logic        pos1_q;
  logic [3:0]  sh1_q;

  always_comb begin
    sf_c = (spreading_factor_i < SF_MIN) ? SF_MIN :
           (spreading_factor_i > SF_MAX) ? SF_MAX : spreading_factor_i;
    cr_c = (coding_rate_i < CR_MIN) ? CR_MIN :
           (coding_rate_i > CR_MAX) ? CR_MAX : coding_rate_i;
    bw_c = (bandwidth_code_i > BW_MAX) ? BW_MAX : bandwidth_code_i;
    num  = {2'b00, payload_length_i, 3'b000} + 13'd44 - {7'b0, sf_c, 2'b00}
         - (implicit_header_i ? 13'd20 : 13'd0);
    pos  = !num[12] && (num != 13'd0);
    dv   = sf_c - {2'b00, low_rate_optimize_i, 1'b0};
    // ceil(num / 4d) == floor(floor((num + 4d - 1) / 4) / d)
    x    = num + {7'b0, dv, 2'b00} - 13'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    n1_q   <= x[11:2];
    r1_q   <= lta_recip(dv);
    cr1_q  <= cr_c;
    pos1_q <= pos;
    sh1_q  <= sf_c + 4'd1 - {2'b00, bw_c};
  end

  // stage 2: reciprocal multiply
  logic [25:0] prod;
  logic        v2_q;
  logic [7:0]  q2_q;
  logic [2:0]  cr2_q;
  logic        pos2_q;
  logic [3:0]  sh2_q;

  assign prod = n1_q * r1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    q2_q   <= prod[25:RECIP_SHIFT];
    cr2_q  <= cr1_q;
    pos2_q <= pos1_q;
    sh2_q  <= sh1_q;
  end

  // stage 3: scale by CR+4, add the fixed eight
  logic [11:0] blk;
  logic        v3_q;
  lta_sym_t    sym3_q;

  assign blk = q2_q * ({1'b0, cr2_q} + 4'd4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sym3_q.symbols <= 10'd8 + (pos2_q ? blk[9:0] : 10'd0);
    sym3_q.shift   <= sh2_q;
  end

  assign valid_o = v3_q;
  assign sym_o   = sym3_q;

endmodule

>>> rtl/lora_time_on_air_top.sv
// Top level of the LoRa packet airtime calculator.
//
// Usage: drive the packet description on the input ports and pulse start;
// a beat is taken at every edge with start high and busy low. busy is
// always low, so a new packet may enter every cycle and throughput is one
// packet per clock.
// The result appears on payload_symbols_o and airtime_us_o for exactly one
// cycle, marked by done_o; results leave in input order. The five register
// stages are: clamp and reciprocal lookup, reciprocal multiply, coding-rate
// scale, preamble sum, final shift.
// The receiver cannot stall; it must take every done_o beat.
// preamble_length is written through cfg_valid_i/cfg_ready_o/cfg_data_i;
// the user must do so only while no packet is in flight, which the block
// does not enforce: cfg_ready_o is always high.
// Reset clears all pipeline valid bits (no done_o afterwards until a new
// start) and sets the preamble length to 8.
module lora_time_on_air_top import lta_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  spreading_factor_i,
  input  logic [7:0]  payload_length_i,
  input  logic [2:0]  coding_rate_i,
  input  logic [1:0]  bandwidth_code_i,
  input  logic        implicit_header_i,
  input  logic        low_rate_optimize_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  output logic        done_o,
  output logic [9:0]  payload_symbols_o,
  output logic [31:0] airtime_us_o
);

  logic [15:0] preamble_q;
  logic        s3_valid;
  lta_sym_t    s3_sym;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_q <= PREAMBLE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      preamble_q <= cfg_data_i;
    end
  end

  lta_sym u_sym (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (start && !busy),
    .spreading_factor_i (spreading_factor_i),
    .payload_length_i   (payload_length_i),
    .coding_rate_i      (coding_rate_i),
    .bandwidth_code_i   (bandwidth_code_i),
    .implicit_header_i  (implicit_header_i),
    .low_rate_optimize_i(low_rate_optimize_i),
    .valid_o            (s3_valid),
    .sym_o              (s3_sym)
  );

  // stage 4: quarter-symbol count of the whole packet
  logic [16:0] sum;
  logic        v4_q;
  logic [18:0] quarters4_q;
  lta_sym_t    sym4_q;

  assign sum = {1'b0, preamble_q} + {7'b0, s3_sym.symbols};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= s3_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    quarters4_q <= {sum, 2'b00} + 19'd17;
    sym4_q      <= s3_sym;
  end

  // stage 5: scale by 2^(SF+1-BW) into microseconds
  logic [31:0] airtime;
  logic        done_q;
  logic [9:0]  symbols_q;
  logic [31:0] airtime_q;

  assign airtime = {13'b0, quarters4_q} << sym4_q.shift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    symbols_q <= sym4_q.symbols;
    airtime_q <= airtime;
  end

  assign done_o            = done_q;
  assign payload_symbols_o = symbols_q;
  assign airtime_us_o      = airtime_q;

  a_done_follows_s4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(v4_q))
    else $error("done strobe does not follow stage-4 valid");

  a_symbols_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (payload_symbols_o >= 10'd8 && payload_symbols_o <= 10'd832))
    else $error("payload symbol count out of range");

  a_airtime_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (airtime_us_o[5:0] == 6'd0))
    else $error("airtime not a multiple of the minimum symbol quarter");

endmodule

>>> tb/sv/lta_checker.sv
// Checker for the LoRa airtime calculator: predicts each packet result and compares it.
module lta_checker import lta_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [3:0]  spreading_factor_i,
  input  logic [7:0]  payload_length_i,
  input  logic [2:0]  coding_rate_i,
  input  logic [1:0]  bandwidth_code_i,
  input  logic        implicit_header_i,
  input  logic        low_rate_optimize_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  input  logic        done_i,
  input  logic [9:0]  payload_symbols_i,
  input  logic [31:0] airtime_us_i,
  output int          mismatch_count_o,
  output int          pending_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [9:0]  symbols;
    logic [31:0] airtime;
  } airtime_result_t;

  airtime_result_t airtime_queue[$];
  logic [15:0]     preamble_copy;
  int              error_total;

  function automatic airtime_result_t predict_airtime(
    input logic [3:0]  sf_raw,
    input logic [7:0]  pl,
    input logic [2:0]  cr_raw,
    input logic [1:0]  bw_raw,
    input logic        ih,
    input logic        de,
    input logic [15:0] preamble
  );
    logic [3:0]      sf;
    logic [2:0]      cr;
    logic [1:0]      bw;
    int              num;
    int              den;
    int              blocks;
    int unsigned     symbols;
    int unsigned     quarters;
    logic [63:0]     air;
    airtime_result_t res;
    sf = (sf_raw < SF_MIN) ? SF_MIN : ((sf_raw > SF_MAX) ? SF_MAX : sf_raw);
    cr = (cr_raw < CR_MIN) ? CR_MIN : ((cr_raw > CR_MAX) ? CR_MAX : cr_raw);
    bw = (bw_raw > BW_MAX) ? BW_MAX : bw_raw;
    num = 8 * int'(pl) - 4 * int'(sf) + 44 - 20 * int'(ih);
    den = 4 * (int'(sf) - 2 * int'(de));
    // ceiling first, then scale by the coding rate
    blocks = (num > 0) ? (num + den - 1) / den : 0;
    symbols = 8 + blocks * (int'(cr) + 4);
    quarters = 4 * (int'(preamble) + symbols) + 17;
    air = 64'(quarters) << (int'(sf) + 1 - int'(bw));
    res.symbols = symbols[9:0];
    res.airtime = air[31:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    airtime_result_t want;
    airtime_result_t next_item;
    if (!rst_ni) begin
      airtime_queue.delete();
      preamble_copy = PREAMBLE_RESET;
      error_total = 0;
      mismatch_count_o <= 0;
      pending_count_o <= 0;
    end else begin
      // check the outgoing beat before queueing a new one
      if (done_i) begin
        if (airtime_queue.size() == 0) begin
          error_total++;
          if (error_total <= REPORT_LIMIT)
            $display("unexpected result: symbols %0d airtime %0d",
                     payload_symbols_i, airtime_us_i);
        end else begin
          want = airtime_queue.pop_front();
          if (payload_symbols_i !== want.symbols || airtime_us_i !== want.airtime) begin
            error_total++;
            if (error_total <= REPORT_LIMIT)
              $display("mismatch: expected symbols %0d airtime %0d, got symbols %0d airtime %0d",
                       want.symbols, want.airtime, payload_symbols_i, airtime_us_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i)
        preamble_copy = cfg_data_i;
      if (start_i && !busy_i) begin
        next_item = predict_airtime(spreading_factor_i, payload_length_i,
                                    coding_rate_i, bandwidth_code_i,
                                    implicit_header_i, low_rate_optimize_i,
                                    preamble_copy);
        airtime_queue.insert(airtime_queue.size(), next_item);
      end
      mismatch_count_o <= error_total;
      pending_count_o <= airtime_queue.size();
    end
  end

endmodule

>>> tb/sv/tb.sv
// Testbench top for the LoRa airtime calculator: stimulus, configuration phases and verdict.
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_ITEMS  = 145;

  logic        clk_i               = 1'b0;
  logic        rst_ni              = 1'b0;
  logic        start               = 1'b0;
  logic        busy;
  logic [3:0]  spreading_factor_i  = 4'd7;
  logic [7:0]  payload_length_i    = 8'd0;
  logic [2:0]  coding_rate_i       = 3'd1;
  logic [1:0]  bandwidth_code_i    = 2'd0;
  logic        implicit_header_i   = 1'b0;
  logic        low_rate_optimize_i = 1'b0;
  logic        cfg_valid_i         = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i          = 16'd0;
  logic        done_o;
  logic [9:0]  payload_symbols_o;
  logic [31:0] airtime_us_o;
  int          mismatch_count;
  int          pending_count;
  int          cycle_count = 0;

  lora_time_on_air_top uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .spreading_factor_i  (spreading_factor_i),
    .payload_length_i    (payload_length_i),
    .coding_rate_i       (coding_rate_i),
    .bandwidth_code_i    (bandwidth_code_i),
    .implicit_header_i   (implicit_header_i),
    .low_rate_optimize_i (low_rate_optimize_i),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_data_i          (cfg_data_i),
    .done_o              (done_o),
    .payload_symbols_o   (payload_symbols_o),
    .airtime_us_o        (airtime_us_o)
  );

  lta_checker checker_inst (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start),
    .busy_i              (busy),
    .spreading_factor_i  (spreading_factor_i),
    .payload_length_i    (payload_length_i),
    .coding_rate_i       (coding_rate_i),
    .bandwidth_code_i    (bandwidth_code_i),
    .implicit_header_i   (implicit_header_i),
    .low_rate_optimize_i (low_rate_optimize_i),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_i         (cfg_ready_o),
    .cfg_data_i          (cfg_data_i),
    .done_i              (done_o),
    .payload_symbols_i   (payload_symbols_o),
    .airtime_us_i        (airtime_us_o),
    .mismatch_count_o    (mismatch_count),
    .pending_count_o     (pending_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one packet, hold until the beat is taken, then idle for the given gap.
  task automatic send_packet(input logic [3:0] sf, input logic [7:0] pl, input logic [2:0] cr,
                             input logic [1:0] bw, input logic ih, input logic de,
                             input int gap);
    spreading_factor_i  <= sf;
    payload_length_i    <= pl;
    coding_rate_i       <= cr;
    bandwidth_code_i    <= bw;
    implicit_header_i   <= ih;
    low_rate_optimize_i <= de;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random(input int gap);
    logic [3:0] sf;
    logic [7:0] pl;
    logic [2:0] cr;
    logic [1:0] bw;
    if ($urandom_range(0, 9) == 0) begin
      // noise: any value the ports allow
      sf = 4'($urandom());
      pl = 8'($urandom());
      cr = 3'($urandom());
      bw = 2'($urandom());
    end else begin
      sf = 4'($urandom_range(7, 12));
      pl = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 8)) : 8'($urandom_range(0, 255));
      cr = 3'($urandom_range(1, 4));
      bw = 2'($urandom_range(0, 2));
    end
    send_packet(sf, pl, cr, bw, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), gap);
  endtask

  // Drop start and hold off until every expected result has arrived.
  task automatic drain();
    start <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_preamble(input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(input int count, input bit allow_gaps);
    bit burst;
    burst = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) burst = !allow_gaps || ($urandom_range(0, 3) == 0);
      if (i == count / 2) drain();
      send_random(burst ? 0 : pick_gap());
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed packets under the reset preamble
    send_packet(4'd7,  8'd0,   3'd1, 2'd0, 1'b0, 1'b0, 0);
    send_packet(4'd12, 8'd255, 3'd4, 2'd2, 1'b1, 1'b1, 0);
    send_packet(4'd7,  8'd255, 3'd4, 2'd0, 1'b0, 1'b1, 1);
    send_packet(4'd7,  8'd255, 3'd4, 2'd0, 1'b0, 1'b0, 0);
    // numerator at or below zero, then packets with a positive numerator
    send_packet(4'd12, 8'd0,   3'd1, 2'd0, 1'b1, 1'b0, 2);
    send_packet(4'd12, 8'd0,   3'd4, 2'd1, 1'b1, 1'b1, 0);
    send_packet(4'd11, 8'd1,   3'd2, 2'd2, 1'b1, 1'b0, 0);
    send_packet(4'd8,  8'd10,  3'd2, 2'd1, 1'b0, 1'b0, 0);
    send_packet(4'd9,  8'd50,  3'd3, 2'd2, 1'b0, 1'b1, 3);
    send_packet(4'd10, 8'd100, 3'd4, 2'd0, 1'b1, 1'b0, 0);
    send_packet(4'd11, 8'd200, 3'd1, 2'd1, 1'b1, 1'b1, 0);
    send_packet(4'd12, 8'd255, 3'd4, 2'd0, 1'b0, 1'b0, 12);
    // out-of-range spreading factor saturates
    send_packet(4'd0,  8'd20,  3'd1, 2'd0, 1'b0, 1'b0, 0);
    send_packet(4'd6,  8'd20,  3'd2, 2'd0, 1'b0, 1'b1, 0);
    send_packet(4'd13, 8'd20,  3'd3, 2'd1, 1'b0, 1'b0, 0);
    send_packet(4'd15, 8'd170, 3'd2, 2'd1, 1'b1, 1'b1, 1);
    // out-of-range coding rate saturates
    send_packet(4'd7,  8'd30,  3'd0, 2'd0, 1'b0, 1'b0, 0);
    send_packet(4'd7,  8'd30,  3'd5, 2'd0, 1'b0, 1'b0, 0);
    send_packet(4'd9,  8'd85,  3'd7, 2'd2, 1'b1, 1'b0, 0);
    // bandwidth code 3 acts as 500 kHz
    send_packet(4'd9,  8'd40,  3'd2, 2'd3, 1'b0, 1'b0, 0);
    send_packet(4'd12, 8'd255, 3'd4, 2'd3, 1'b1, 1'b0, 0);
    send_packet(4'd7,  8'd64,  3'd3, 2'd3, 1'b0, 1'b1, 0);
    drain();

    write_preamble(16'd6);
    run_random(PHASE_ITEMS, 1'b1);
    write_preamble(16'hFFFF);
    send_packet(4'd12, 8'd255, 3'd4, 2'd0, 1'b0, 1'b1, 0);
    send_packet(4'd12, 8'd255, 3'd1, 2'd0, 1'b1, 1'b0, 0);
    run_random(PHASE_ITEMS, 1'b0);
    // below the usual minimum, used as programmed
    write_preamble(16'd0);
    run_random(PHASE_ITEMS, 1'b1);
    write_preamble(16'($urandom_range(6, 65535)));
    run_random(PHASE_ITEMS, 1'b1);
    write_preamble(16'h5555);
    run_random(PHASE_ITEMS, 1'b1);
    write_preamble(16'd8);
    run_random(30, 1'b1);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
